[sv/nfcfp_pkg.sv]
// shared types, codes and constants of the frame byte parser
package nfcfp_pkg;

    // frame size limit (total bytes counted from buffer slot 0)
    localparam logic [8:0] MAX_FRAME_BYTES = 9'd64;

    // byte values used by the parser
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_WAKE = 8'h55;

    // register reset values
    localparam logic       RESERVED_OFFSET_RESET = 1'b0;
    localparam logic [7:0] FRAME_ID_RESET        = 8'hD5;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RESERVED_OFFSET = 1'b0,
        CFG_FRAME_ID        = 1'b1
    } cfg_index_t;

    // parser phases
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_LCS  = 3'd2,
        PH_TFI  = 3'd3,
        PH_EXT  = 3'd4,
        PH_DATA = 3'd5
    } phase_t;

    // per-byte status codes
    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_DONE    = 3'd1,
        ST_ACK     = 3'd2,
        ST_WAKEUP  = 3'd3,
        ST_CSUM    = 3'd4,
        ST_DROPPED = 3'd5
    } status_t;

    // parser state carried from byte to byte
    typedef struct packed {
        phase_t     phase;
        logic [7:0] write_position;
        logic [7:0] expected_count;
        logic [7:0] running_sum;
        logic [7:0] previous_byte;
        logic [1:0] wake_countdown;
        logic [7:0] length_byte;
        logic [7:0] length_check_byte;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:             PH_HUNT,
        write_position:    8'd0,
        expected_count:    8'd0,
        running_sum:       8'd0,
        previous_byte:     BYTE_ONE,
        wake_countdown:    2'd0,
        length_byte:       8'd0,
        length_check_byte: 8'd0
    };

    // one result per byte
    typedef struct packed {
        status_t    status;
        logic       start_found;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] frame_length;
    } parse_result_t;

    // configuration seen by the parser
    typedef struct packed {
        logic       reserved_offset;
        logic [7:0] expected_frame_id;
    } parse_cfg_t;

endpackage

[sv/nfcfp_cfg.sv]
// configuration registers of the frame byte parser
module nfcfp_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nfcfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                        cfg_data,
    output nfcfp_pkg::parse_cfg_t             cfg
);
    import nfcfp_pkg::*;

    parse_cfg_t cfg_reg;

    // register writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reserved_offset   <= RESERVED_OFFSET_RESET;
            cfg_reg.expected_frame_id <= FRAME_ID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RESERVED_OFFSET: cfg_reg.reserved_offset   <= cfg_data[0];
                CFG_FRAME_ID:        cfg_reg.expected_frame_id <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/nfcfp_step.sv]
// per-byte decision logic: next parser state and result from one byte
module nfcfp_step
(
    input  nfcfp_pkg::parse_state_t  cur,
    input  logic [7:0]               rx_byte,
    input  nfcfp_pkg::parse_cfg_t    cfg,
    output nfcfp_pkg::parse_state_t  nxt,
    output nfcfp_pkg::parse_result_t res
);
    import nfcfp_pkg::*;

    logic [7:0] wp_inc;
    logic [7:0] sum_next;
    logic [7:0] len_sum;
    logic [8:0] total;
    logic [7:0] offset_ext;

    // shared arithmetic
    assign wp_inc     = cur.write_position + 8'd1;
    assign sum_next   = cur.running_sum + rx_byte;
    assign len_sum    = cur.length_byte + cur.length_check_byte;
    assign total      = {1'b0, cur.expected_count} + {1'b0, cur.length_byte};
    assign offset_ext = {7'd0, cfg.reserved_offset};

    always_comb
    begin
        nxt = cur;
        res = '{status: ST_BUSY, start_found: 1'b0, store_valid: 1'b0,
                store_index: 8'd0, frame_length: 8'd0};

        case (cur.phase)
            PH_HUNT:
            begin
                if (cur.write_position != 8'd0)
                begin
                    // first byte after a finished frame only clears
                    nxt = STATE_CLEAR;
                end
                else if (rx_byte == BYTE_FF && cur.previous_byte == BYTE_ZERO)
                begin
                    nxt.write_position = offset_ext + 8'd3;
                    nxt.expected_count = offset_ext + 8'd5;
                    nxt.phase          = PH_LEN;
                    res.start_found    = 1'b1;
                end
                else if (rx_byte == BYTE_WAKE && cur.previous_byte == BYTE_WAKE)
                begin
                    nxt.wake_countdown = 2'd3;
                end
                else if (cur.wake_countdown != 2'd0)
                begin
                    if (rx_byte != BYTE_ZERO)
                    begin
                        nxt.wake_countdown = 2'd0;
                    end
                    else
                    begin
                        nxt.wake_countdown = cur.wake_countdown - 2'd1;
                        if (cur.wake_countdown == 2'd1)
                        begin
                            res.status = ST_WAKEUP;
                        end
                    end
                end
            end

            PH_LEN:
            begin
                res.store_valid    = 1'b1;
                res.store_index    = cur.write_position;
                nxt.write_position = wp_inc;
                nxt.length_byte    = rx_byte;
                nxt.phase          = PH_LCS;
            end

            PH_LCS:
            begin
                res.store_valid       = 1'b1;
                res.store_index       = cur.write_position;
                nxt.write_position    = wp_inc;
                nxt.length_check_byte = rx_byte;
                if (cur.length_byte == BYTE_FF && rx_byte == BYTE_FF)
                begin
                    // extended frame
                    nxt.expected_count = cur.expected_count + 8'd4;
                    nxt.phase          = PH_EXT;
                end
                else if ((cur.length_byte == BYTE_FF && rx_byte == BYTE_ZERO) ||
                         (cur.length_byte == BYTE_ZERO && rx_byte == BYTE_FF))
                begin
                    // ack or nack
                    res.status       = ST_ACK;
                    res.frame_length = wp_inc;
                    nxt.phase        = PH_HUNT;
                end
                else
                begin
                    nxt.expected_count = cur.expected_count + 8'd1;
                    nxt.phase          = PH_TFI;
                end
            end

            PH_EXT:
            begin
                nxt        = STATE_CLEAR;
                res.status = ST_DROPPED;
            end

            PH_TFI:
            begin
                res.store_valid    = 1'b1;
                res.store_index    = cur.write_position;
                nxt.write_position = wp_inc;
                if (cur.length_byte == BYTE_ONE && cur.length_check_byte == BYTE_FF)
                begin
                    // error frame: no identifier check
                    nxt.expected_count = cur.expected_count + 8'd1;
                    nxt.running_sum    = rx_byte;
                    nxt.phase          = PH_DATA;
                end
                else if (len_sum == 8'd0)
                begin
                    if (total > MAX_FRAME_BYTES)
                    begin
                        nxt        = STATE_CLEAR;
                        res.status = ST_DROPPED;
                    end
                    else if (rx_byte == cfg.expected_frame_id)
                    begin
                        nxt.expected_count = total[7:0];
                        nxt.running_sum    = cfg.expected_frame_id;
                        nxt.phase          = PH_DATA;
                    end
                    else
                    begin
                        nxt        = STATE_CLEAR;
                        res.status = ST_DROPPED;
                    end
                end
                else
                begin
                    // bad length checksum
                    nxt        = STATE_CLEAR;
                    res.status = ST_CSUM;
                end
            end

            PH_DATA:
            begin
                res.store_valid    = 1'b1;
                res.store_index    = cur.write_position;
                nxt.write_position = wp_inc;
                nxt.running_sum    = sum_next;
                if (wp_inc >= cur.expected_count)
                begin
                    if (sum_next != 8'd0)
                    begin
                        nxt        = STATE_CLEAR;
                        res.status = ST_CSUM;
                    end
                    else
                    begin
                        res.status       = ST_DONE;
                        res.frame_length = wp_inc;
                        nxt.phase        = PH_HUNT;
                    end
                end
            end

            default:
            begin
                nxt        = STATE_CLEAR;
                res.status = ST_DROPPED;
            end
        endcase

        // every byte is remembered for start code and wake-up detection
        nxt.previous_byte = rx_byte;
    end

endmodule

[sv/nfc_frame_byte_parser_core.sv]
// top level of the frame byte parser: input register, decision logic, result register
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid / tready    tdata[7:0] rx_byte
//  m_axis    out  tvalid / tready    tuser[2:0] status, tdata[17:0] result fields
//  cfg       in   cfg_we             cfg_index selects register, cfg_data value
//
// one byte per cycle sustained while m_axis does not stall; a beat is held in the input register
// and then sits in the result register, from which its result is offered on m_axis.
// the parser state advances in the same cycle a byte moves to the result register.
// reset clears parser state, both valid flags and the configuration registers.
// a stalled result register holds the input register, which then stalls s_axis.
module nfc_frame_byte_parser_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,   // [0] start_found,
                                                              // [1] store_valid,
                                                              // [9:2] store_index,
                                                              // [17:10] frame_length
    output logic [2:0]                        m_axis_tuser,   // [2:0] status
    // configuration
    input  logic                              cfg_we,
    input  logic [nfcfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                        cfg_data
);
    import nfcfp_pkg::*;

    parse_cfg_t    cfg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t res_next;
    parse_result_t res_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    logic          advance;
    logic          s_fire;

    nfcfp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nfcfp_step u_step
    (
        .cur     (state_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .nxt     (state_next),
        .res     (res_next)
    );

    // handshake control
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // parser state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.status;
    assign m_axis_tdata  = {6'd0, res_reg.frame_length, res_reg.store_index,
                            res_reg.store_valid, res_reg.start_found};

    // a start code byte is never itself stored
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.start_found |-> !res_reg.store_valid)
        else $error("start code byte marked for storage");

    // frame length only accompanies a finished frame or an ack
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.frame_length != 8'd0 |->
            (res_reg.status == ST_DONE || res_reg.status == ST_ACK))
        else $error("frame length reported without a finished frame");

    // an unstored byte carries no slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.store_valid |-> res_reg.store_index == 8'd0)
        else $error("slot given for an unstored byte");

    // a stalled result holds the parser state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> $stable(state_reg))
        else $error("parser state moved while result stalled");

    // the input side stalls only with a byte waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with nothing pending");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for the frame byte parser: framed byte streams, result scoreboard, random stalls
module testbench;

    import nfcfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    // scoreboard: tracks parser state and configuration, predicts one result per byte
    class frame_scoreboard;
        parse_cfg_t    cfg;
        parse_state_t  st;
        parse_result_t want_q[$];
        int unsigned   mismatches;
        int unsigned   bytes_seen;
        int unsigned   results_checked;
        int unsigned   starts_seen;
        int unsigned   status_seen[6];

        function new();
            cfg.reserved_offset   = RESERVED_OFFSET_RESET;
            cfg.expected_frame_id = FRAME_ID_RESET;
            st                    = STATE_CLEAR;
            mismatches            = 0;
            bytes_seen            = 0;
            results_checked       = 0;
            starts_seen           = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [7:0] value);
            case (idx)
                CFG_RESERVED_OFFSET: cfg.reserved_offset   = value[0];
                CFG_FRAME_ID:        cfg.expected_frame_id = value;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return want_q.size();
        endfunction

        task report(string msg);
            if (mismatches < 30)
                $display("[%0t] error: %s", $time, msg);
            mismatches++;
        endtask

        // advance the parser by one received byte and queue the result it must give
        function void note_input(logic [7:0] d);
            parse_result_t r;
            logic [8:0]    total;
            r = '0;
            r.status = ST_BUSY;
            case (st.phase)
                PH_HUNT:
                begin
                    if (st.write_position != 8'd0)
                        st = STATE_CLEAR;
                    else if (d == BYTE_FF && st.previous_byte == BYTE_ZERO)
                    begin
                        st.write_position = {7'd0, cfg.reserved_offset} + 8'd3;
                        st.expected_count = st.write_position + 8'd2;
                        st.phase          = PH_LEN;
                        r.start_found     = 1'b1;
                    end
                    else if (d == BYTE_WAKE && st.previous_byte == BYTE_WAKE)
                        st.wake_countdown = 2'd3;
                    else if (st.wake_countdown != 2'd0)
                    begin
                        if (d != BYTE_ZERO)
                            st.wake_countdown = 2'd0;
                        else
                        begin
                            st.wake_countdown = st.wake_countdown - 2'd1;
                            if (st.wake_countdown == 2'd0)
                                r.status = ST_WAKEUP;
                        end
                    end
                end
                PH_LEN:
                begin
                    r.store_valid     = 1'b1;
                    r.store_index     = st.write_position;
                    st.write_position = st.write_position + 8'd1;
                    st.length_byte    = d;
                    st.phase          = PH_LCS;
                end
                PH_LCS:
                begin
                    r.store_valid        = 1'b1;
                    r.store_index        = st.write_position;
                    st.write_position    = st.write_position + 8'd1;
                    st.length_check_byte = d;
                    if (st.length_byte == BYTE_FF && d == BYTE_FF)
                    begin
                        st.expected_count = st.expected_count + 8'd4;
                        st.phase          = PH_EXT;
                    end
                    else if ((st.length_byte == BYTE_FF && d == BYTE_ZERO) ||
                             (st.length_byte == BYTE_ZERO && d == BYTE_FF))
                    begin
                        r.status       = ST_ACK;
                        r.frame_length = st.write_position;
                        st.phase       = PH_HUNT;
                    end
                    else
                    begin
                        st.expected_count = st.expected_count + 8'd1;
                        st.phase          = PH_TFI;
                    end
                end
                PH_EXT:
                begin
                    st       = STATE_CLEAR;
                    r.status = ST_DROPPED;
                end
                PH_TFI:
                begin
                    r.store_valid     = 1'b1;
                    r.store_index     = st.write_position;
                    st.write_position = st.write_position + 8'd1;
                    // error frame: no identifier check, sum starts at this byte
                    if (st.length_byte == BYTE_ONE && st.length_check_byte == BYTE_FF)
                    begin
                        st.expected_count = st.expected_count + 8'd1;
                        st.running_sum    = d;
                        st.phase          = PH_DATA;
                    end
                    else if (st.length_byte + st.length_check_byte == 8'd0)
                    begin
                        total = {1'b0, st.expected_count} + {1'b0, st.length_byte};
                        if (total > MAX_FRAME_BYTES)
                        begin
                            st       = STATE_CLEAR;
                            r.status = ST_DROPPED;
                        end
                        else if (d == cfg.expected_frame_id)
                        begin
                            st.expected_count = total[7:0];
                            st.running_sum    = cfg.expected_frame_id;
                            st.phase          = PH_DATA;
                        end
                        else
                        begin
                            st       = STATE_CLEAR;
                            r.status = ST_DROPPED;
                        end
                    end
                    else
                    begin
                        st       = STATE_CLEAR;
                        r.status = ST_CSUM;
                    end
                end
                PH_DATA:
                begin
                    r.store_valid     = 1'b1;
                    r.store_index     = st.write_position;
                    st.write_position = st.write_position + 8'd1;
                    st.running_sum    = st.running_sum + d;
                    if (st.write_position >= st.expected_count)
                    begin
                        if (st.running_sum != 8'd0)
                        begin
                            st       = STATE_CLEAR;
                            r.status = ST_CSUM;
                        end
                        else
                        begin
                            r.status       = ST_DONE;
                            r.frame_length = st.write_position;
                            st.phase       = PH_HUNT;
                        end
                    end
                end
                default:
                begin
                    st       = STATE_CLEAR;
                    r.status = ST_DROPPED;
                end
            endcase
            st.previous_byte = d;
            bytes_seen++;
            starts_seen += r.start_found;
            status_seen[r.status]++;
            want_q.push_back(r);
        endfunction

        // compare one result beat against the oldest prediction
        task check_result(logic [2:0] status_bits, logic [23:0] payload);
            parse_result_t want;
            if (want_q.size() == 0)
            begin
                report($sformatf("result with none expected: status %0d data %h",
                                 status_bits, payload));
                return;
            end
            want = want_q.pop_front();
            results_checked++;
            if (status_bits !== want.status)
                report($sformatf("result %0d status %0d, expected %s",
                                 results_checked, status_bits, want.status.name()));
            if (payload[0] !== want.start_found)
                report($sformatf("result %0d start_found %b, expected %b",
                                 results_checked, payload[0], want.start_found));
            if (payload[1] !== want.store_valid)
                report($sformatf("result %0d store_valid %b, expected %b",
                                 results_checked, payload[1], want.store_valid));
            if (payload[9:2] !== want.store_index)
                report($sformatf("result %0d store_index %0d, expected %0d",
                                 results_checked, payload[9:2], want.store_index));
            if (payload[17:10] !== want.frame_length)
                report($sformatf("result %0d frame_length %0d, expected %0d",
                                 results_checked, payload[17:10], want.frame_length));
            if (payload[23:18] !== 6'd0)
                report($sformatf("result %0d pad bits %b, expected zero",
                                 results_checked, payload[23:18]));
        endtask

        task finish_check();
            if (want_q.size() != 0)
                report($sformatf("%0d results never arrived", want_q.size()));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_RESERVED_OFFSET;
    logic [7:0]  cfg_data = 8'd0;

    frame_scoreboard sb = new();
    logic [7:0]      tx_q[$];
    bit              send_idle = 1'b1;
    bit              recv_idle = 1'b1;
    logic            hold_off = 1'b0;
    int unsigned     cycle_count = 0;

    nfc_frame_byte_parser_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // beat monitor on both streams
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    // result side: random stall per beat while recv_idle is set, long hold-off on request
    initial
    begin
        int unsigned stall;
        forever
        begin
            stall = recv_idle ? $urandom_range(0, 13) : 0;
            if (stall != 0 || hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // long receiver hold-off so the input side backs up
    task automatic hold_off_run();
        repeat (30) @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    // drive queued bytes with a random gap before each beat while send_idle is set
    task automatic send_queue();
        int unsigned gap;
        logic [7:0]  b;
        while (tx_q.size() != 0)
        begin
            b   = tx_q.pop_front();
            gap = send_idle ? $urandom_range(0, 13) : 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= b;
            do @(posedge clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // let the monitor note the last beat sent before waiting for pending results
    task automatic drain();
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // byte sequence builders
    function automatic void push_start();
        tx_q.push_back(BYTE_ZERO);
        tx_q.push_back(BYTE_FF);
    endfunction

    function automatic void push_frame(int unsigned n_data, logic [7:0] id,
                                       bit bad_lcs, bit bad_dcs);
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        len = 8'(n_data + 1);
        push_start();
        tx_q.push_back(len);
        if (bad_lcs)
            tx_q.push_back(8'd0 - len + 8'($urandom_range(1, 255)));
        else
            tx_q.push_back(8'd0 - len);
        tx_q.push_back(id);
        sum = id;
        for (int unsigned i = 0; i < n_data; i++)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            tx_q.push_back(b);
        end
        if (bad_dcs)
            tx_q.push_back(8'd0 - sum + 8'($urandom_range(1, 255)));
        else
            tx_q.push_back(8'd0 - sum);
    endfunction

    function automatic void push_ack(bit nack);
        push_start();
        tx_q.push_back(nack ? BYTE_FF : BYTE_ZERO);
        tx_q.push_back(nack ? BYTE_ZERO : BYTE_FF);
    endfunction

    function automatic void push_wakeup(bit broken);
        tx_q.push_back(BYTE_WAKE);
        tx_q.push_back(BYTE_WAKE);
        tx_q.push_back(BYTE_ZERO);
        if (broken)
            tx_q.push_back(8'($urandom_range(1, 255)));
        tx_q.push_back(BYTE_ZERO);
        tx_q.push_back(BYTE_ZERO);
    endfunction

    function automatic void push_extended();
        push_start();
        tx_q.push_back(BYTE_FF);
        tx_q.push_back(BYTE_FF);
        tx_q.push_back(8'($urandom));
    endfunction

    function automatic void push_error_frame(logic [7:0] code, bit bad_dcs);
        push_start();
        tx_q.push_back(BYTE_ONE);
        tx_q.push_back(BYTE_FF);
        tx_q.push_back(code);
        tx_q.push_back(bad_dcs ? ~code : 8'd0 - code);
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return BYTE_ZERO;
            1:       return BYTE_FF;
            2:       return BYTE_WAKE;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly well-formed frames with random content, plus broken ones and noise
    function automatic void build_random(int unsigned n_items);
        int unsigned counted;
        int unsigned sz;
        int unsigned pick;
        int unsigned n_data;
        int unsigned max_ok;
        counted = 0;
        max_ok  = 57 - sb.cfg.reserved_offset;
        while (counted < n_items)
        begin
            sz     = tx_q.size();
            pick   = $urandom_range(0, 99);
            n_data = ($urandom_range(0, 19) == 0) ? $urandom_range(0, max_ok)
                                                  : $urandom_range(0, 8);
            if (pick < 50)
                push_frame(n_data, sb.cfg.expected_frame_id, 1'b0, 1'b0);
            else if (pick < 58)
                push_frame(n_data, sb.cfg.expected_frame_id, 1'b0, 1'b1);
            else if (pick < 63)
                push_frame(n_data, sb.cfg.expected_frame_id, 1'b1, 1'b0);
            else if (pick < 68)
                push_frame(n_data, sb.cfg.expected_frame_id + 8'($urandom_range(1, 255)),
                           1'b0, 1'b0);
            else if (pick < 71)
                push_frame($urandom_range(max_ok + 1, max_ok + 12),
                           sb.cfg.expected_frame_id, 1'b0, 1'b0);
            else if (pick < 76)
                push_ack($urandom_range(0, 1));
            else if (pick < 80)
                push_wakeup($urandom_range(0, 3) == 0);
            else if (pick < 83)
                push_extended();
            else if (pick < 86)
                push_error_frame(8'($urandom), $urandom_range(0, 3) == 0);
            else
            begin
                // noise bytes between items, not counted
                repeat ($urandom_range(1, 6))
                    tx_q.push_back(noise_byte());
                continue;
            end
            counted += tx_q.size() - sz;
        end
    endfunction

    // main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ack, nack, wakeup, extended, error frame, bad length checksum
        push_ack(1'b0);
        push_ack(1'b1);
        push_wakeup(1'b0);
        push_extended();
        push_error_frame(8'h7F, 1'b0);
        push_frame(4, FRAME_ID_RESET, 1'b1, 1'b0);
        send_queue();
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_RESERVED_OFFSET, 8'd1);
                    write_reg(CFG_FRAME_ID, FRAME_ID_RESET);
                    send_idle = 1'b1;
                    recv_idle = 1'b1;
                    // zero-length and identifier-only frames
                    push_frame(0, 8'hD5, 1'b0, 1'b0);
                    push_frame(0, 8'hD5, 1'b0, 1'b0);
                    repeat (6)
                        void'(tx_q.pop_back());
                    tx_q.push_back(BYTE_ZERO);
                    tx_q.push_back(BYTE_FF);
                    tx_q.push_back(BYTE_ZERO);
                    tx_q.push_back(BYTE_ZERO);
                    tx_q.push_back(8'hD5);
                    tx_q.push_back(8'h2B);
                end
                1:
                begin
                    write_reg(CFG_RESERVED_OFFSET, 8'd0);
                    write_reg(CFG_FRAME_ID, 8'h00);
                    send_idle = 1'b0;
                    recv_idle = 1'b0;
                end
                2:
                begin
                    write_reg(CFG_RESERVED_OFFSET, 8'd1);
                    write_reg(CFG_FRAME_ID, 8'hFF);
                    send_idle = 1'b0;
                    recv_idle = 1'b1;
                    fork
                        hold_off_run();
                    join_none
                end
                3:
                begin
                    write_reg(CFG_RESERVED_OFFSET, 8'($urandom_range(0, 1)));
                    write_reg(CFG_FRAME_ID, 8'($urandom));
                    send_idle = 1'b1;
                    recv_idle = 1'b0;
                end
                default:
                begin
                    write_reg(CFG_RESERVED_OFFSET, 8'd0);
                    write_reg(CFG_FRAME_ID, FRAME_ID_RESET);
                    send_idle = 1'b1;
                    recv_idle = 1'b1;
                end
            endcase
            build_random(150);
            send_queue();
            drain();
        end

        repeat (10) @(posedge clk);
        sb.finish_check();
        $display("run covered %0d bytes under six register settings: %0d good frames, %0d ack/nack",
                 sb.bytes_seen, sb.status_seen[ST_DONE], sb.status_seen[ST_ACK]);
        $display("  %0d wakeups, %0d checksum errors, %0d drops, %0d start codes, %0d mismatches",
                 sb.status_seen[ST_WAKEUP], sb.status_seen[ST_CSUM],
                 sb.status_seen[ST_DROPPED], sb.starts_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
